@@ design/assert_macros.svh @@
// Assertion macros shared by the positional sequence table RTL.
// Plain text only, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/pst_pkg.sv @@
// Package of the positional sequence table: sizes, codes, cell command type
// and stream packing offsets. No dependencies.
package pst_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   // fixed field widths of the stream payloads
   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int ITEM_W   = 32;
   localparam int CAP_W    = 7;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // first-hit search tree: groups of eight cells
   localparam int GRP    = 8;
   localparam int GRP_W  = $clog2(GRP);
   localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // request tdata layout
   localparam int REQ_W       = 48;
   localparam int REQ_ACT_LSB = 0;
   localparam int REQ_POS_LSB = REQ_ACT_LSB + ACTION_W;
   localparam int REQ_VAL_LSB = REQ_POS_LSB + POS_W;

   // response tdata layout
   localparam int RSP_W        = 56;
   localparam int RSP_OK_LSB   = 0;
   localparam int RSP_POS_LSB  = 1;
   localparam int RSP_VAL_LSB  = RSP_POS_LSB + POS_W;
   localparam int RSP_REM_LSB  = RSP_VAL_LSB + ITEM_W;
   localparam int RSP_CNT_LSB  = RSP_REM_LSB + POS_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_AT     = 3'd0,
      ACT_INSERT_SORTED = 3'd1,
      ACT_ERASE_AT      = 3'd2,
      ACT_REMOVE_ALL    = 3'd3,
      ACT_FIND          = 3'd4,
      ACT_READ          = 3'd5,
      ACT_WRITE         = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ERASE,
      CELL_WRITE
   } cell_op_type;

   typedef enum logic [1:0] {
      CMP_NONE,
      CMP_EQ,
      CMP_GE,
      CMP_POS
   } cmp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type            op;
      cmp_type                cmp;
      logic [CMP_W-1:0]       pos;
      logic [CMP_W-1:0]       count;
      logic [VALUE_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

@@ design/pst_cell.sv @@
// One entry cell of the table chain: holds a value, shifts with its
// neighbors and flags a match. Depends on pst_pkg.
module pst_cell (
   input  logic                           clock,
   input  logic [pst_pkg::CMP_W-1:0]       cell_index,
   input  pst_pkg::cell_cmd_type           cmd,
   input  logic [pst_pkg::VALUE_WIDTH-1:0] lower_value,
   input  logic [pst_pkg::VALUE_WIDTH-1:0] upper_value,
   output logic [pst_pkg::VALUE_WIDTH-1:0] entry_value,
   output logic                            hit
);
   import pst_pkg::*;

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                   in_use;

   assign in_use      = cell_index < cmd.count;
   assign entry_value = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (cell_index == cmd.pos) entry_in = cmd.value;
            else if (cell_index > cmd.pos) entry_in = lower_value;
         end
         CELL_ERASE: begin
            if (cell_index >= cmd.pos) entry_in = upper_value;
         end
         CELL_WRITE: begin
            if (cell_index == cmd.pos) entry_in = cmd.value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.cmp)
         CMP_EQ:  hit = in_use && (entry_ff == cmd.value);
         CMP_GE:  hit = in_use && (cmd.value <= entry_ff);
         CMP_POS: hit = in_use && (cell_index == cmd.pos);
         default: hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ design/pst_locate.sv @@
// Two-stage registered first-hit search over the cell chain: returns the
// lowest hit index and that cell's value. Depends on pst_pkg.
module pst_locate (
   input  logic                           clock,
   input  logic [pst_pkg::CAPACITY-1:0]    hit,
   input  logic [pst_pkg::VALUE_WIDTH-1:0] cell_value [pst_pkg::CAPACITY],
   output logic                            found,
   output logic [pst_pkg::IDX_W-1:0]       found_index,
   output logic [pst_pkg::VALUE_WIDTH-1:0] found_value
);
   import pst_pkg::*;

   logic                   grp_any_ff [NGRP];
   logic                   grp_any_in [NGRP];
   logic [GRP_W-1:0]       grp_sub_ff [NGRP];
   logic [GRP_W-1:0]       grp_sub_in [NGRP];
   logic [VALUE_WIDTH-1:0] grp_val_ff [NGRP];
   logic [VALUE_WIDTH-1:0] grp_val_in [NGRP];

   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;

   // stage 1: first hit inside each group of eight
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_sub_in[g] = '0;
         grp_val_in[g] = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if ((g * GRP + k) < CAPACITY) begin
               if (hit[g * GRP + k]) begin
                  grp_any_in[g] = 1'b1;
                  grp_sub_in[g] = GRP_W'(k);
                  grp_val_in[g] = cell_value[g * GRP + k];
               end
            end
         end
      end
   end

   // stage 2: first group with a hit
   always_comb begin
      found_in = 1'b0;
      index_in = '0;
      value_in = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found_in = 1'b1;
            index_in = IDX_W'(g * GRP) + IDX_W'(grp_sub_ff[g]);
            value_in = grp_val_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_sub_ff <= grp_sub_in;
      grp_val_ff <= grp_val_in;
      found_ff   <= found_in;
      index_ff   <= index_in;
      value_ff   <= value_in;
   end

   assign found       = found_ff;
   assign found_index = index_ff;
   assign found_value = value_ff;

endmodule

@@ design/positional_sequence_table_top.sv @@
// Top level of the positional sequence table: control sequencer, chain of
// entry cells and first-hit search. Depends on pst_pkg, pst_cell,
// pst_locate and assert_macros.svh.
//
// Usage:
//   req_*   stream of requests, one list operation each (insert at, sorted
//           insert, erase at, remove all, find, read, write).
//   rsp_*   one response per request: ok, position, read value, removed
//           count and the entry count after the operation.
//   csr_*   capacity register; write only while idle (unchecked by the block).
// Timing: one request at a time. Insert at, erase, write, undefined codes and
//   a sorted insert into a full list go from ST_DECODE straight to ST_RESP.
//   Other sorted inserts, find, read pass ST_LOOK1 and ST_LOOK2 first, as
//   set by the two-stage first-hit search. Remove all repeats this search and
//   one chain shift for each removed entry.
// Reset clears the entry count (list empty), the capacity to 64 and the
//   response valid flag; entry contents stay as they are and are never read.
// A stalled receiver holds the finished response in the output register;
//   a new request is still taken, and its response waits until the
//   register frees.
`include "assert_macros.svh"

module positional_sequence_table_top (
   input  logic                      clock,
   input  logic                      reset,
   // request: action[2:0], position[9:3], item_value[41:10], zero fill
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [pst_pkg::REQ_W-1:0] req_tdata,
   // response: ok[0], result_position[7:1], read_value[39:8],
   // removed_count[46:40], entry_count[53:47], zero fill
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [pst_pkg::RSP_W-1:0] rsp_tdata,
   // capacity register
   input  logic                      csr_wr_en,
   input  logic [pst_pkg::CAP_W-1:0] csr_wr_data
);
   import pst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOK1,
      ST_LOOK2,
      ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   action_type             action_ff, action_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       removed_ff, removed_in;
   logic                   res_ok_ff, res_ok_in;
   logic [CNT_W-1:0]       res_pos_ff, res_pos_in;
   logic [VALUE_WIDTH-1:0] res_val_ff, res_val_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]       rsp_tdata_ff, rsp_tdata_in;

   cell_cmd_type           cell_cmd;
   logic [VALUE_WIDTH-1:0] entry_v [CAPACITY];
   logic [VALUE_WIDTH-1:0] lower_v [CAPACITY];
   logic [VALUE_WIDTH-1:0] upper_v [CAPACITY];
   logic [CAPACITY-1:0]    hit_v;

   logic                   loc_found;
   logic [IDX_W-1:0]       loc_index;
   logic [VALUE_WIDTH-1:0] loc_value;

   logic [CMP_W-1:0]       pos_x, cnt_x, sorted_pos;
   logic                   room;

   assign pos_x = CMP_W'(pos_ff);
   assign cnt_x = CMP_W'(count_ff);
   // room for one more: below the register and below the built capacity
   assign room  = (cnt_x < CMP_W'(cap_ff)) && (count_ff < CNT_W'(CAPACITY));
   // sorted insert goes before the first entry >= value, else at the end
   assign sorted_pos = loc_found ? CMP_W'(loc_index) : cnt_x;

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lower_v[i] = '0;
      end else begin : g_lower
         assign lower_v[i] = entry_v[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_v[i] = '0;
      end else begin : g_upper
         assign upper_v[i] = entry_v[i+1];
      end

      pst_cell u_cell (
         .clock       (clock),
         .cell_index  (CMP_W'(i)),
         .cmd         (cell_cmd),
         .lower_value (lower_v[i]),
         .upper_value (upper_v[i]),
         .entry_value (entry_v[i]),
         .hit         (hit_v[i])
      );
   end

   // hits broadcast in ST_DECODE come back in ST_LOOK2
   pst_locate u_locate (
      .clock       (clock),
      .hit         (hit_v),
      .cell_value  (entry_v),
      .found       (loc_found),
      .found_index (loc_index),
      .found_value (loc_value)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      action_in     = action_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      removed_in    = removed_ff;
      res_ok_in     = res_ok_ff;
      res_pos_in    = res_pos_ff;
      res_val_in    = res_val_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      cell_cmd.op    = CELL_HOLD;
      cell_cmd.cmp   = CMP_NONE;
      cell_cmd.pos   = pos_x;
      cell_cmd.count = cnt_x;
      cell_cmd.value = value_ff;

      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in  = action_type'(req_tdata[REQ_ACT_LSB +: ACTION_W]);
               pos_in     = req_tdata[REQ_POS_LSB +: POS_W];
               value_in   = req_tdata[REQ_VAL_LSB +: VALUE_WIDTH];
               removed_in = '0;
               res_ok_in  = 1'b0;
               res_pos_in = '0;
               res_val_in = '0;
               state_in   = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_RESP;
            unique case (action_ff)
               ACT_INSERT_AT: begin
                  if ((pos_x <= cnt_x) && room) begin
                     cell_cmd.op = CELL_INSERT;
                     count_in    = count_ff + CNT_W'(1);
                     res_ok_in   = 1'b1;
                     res_pos_in  = CNT_W'(pos_ff);
                  end
               end
               ACT_INSERT_SORTED: begin
                  if (room) begin
                     cell_cmd.cmp = CMP_GE;
                     state_in     = ST_LOOK1;
                  end
               end
               ACT_ERASE_AT: begin
                  if (pos_x < cnt_x) begin
                     cell_cmd.op = CELL_ERASE;
                     count_in    = count_ff - CNT_W'(1);
                     res_ok_in   = 1'b1;
                  end
               end
               ACT_REMOVE_ALL, ACT_FIND: begin
                  cell_cmd.cmp = CMP_EQ;
                  state_in     = ST_LOOK1;
               end
               ACT_READ: begin
                  cell_cmd.cmp = CMP_POS;
                  state_in     = ST_LOOK1;
               end
               ACT_WRITE: begin
                  if (pos_x < cnt_x) begin
                     cell_cmd.op = CELL_WRITE;
                     res_ok_in   = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_LOOK1: begin
            state_in = ST_LOOK2;
         end

         ST_LOOK2: begin
            state_in = ST_RESP;
            unique case (action_ff)
               ACT_INSERT_SORTED: begin
                  cell_cmd.op  = CELL_INSERT;
                  cell_cmd.pos = sorted_pos;
                  count_in     = count_ff + CNT_W'(1);
                  res_ok_in    = 1'b1;
                  res_pos_in   = CNT_W'(sorted_pos);
               end
               ACT_FIND: begin
                  if (loc_found) begin
                     res_ok_in  = 1'b1;
                     res_pos_in = CNT_W'(loc_index);
                  end
               end
               ACT_READ: begin
                  if (loc_found) begin
                     res_ok_in  = 1'b1;
                     res_val_in = loc_value;
                  end
               end
               ACT_REMOVE_ALL: begin
                  // drop the first match, then search again on the new list
                  if (loc_found) begin
                     cell_cmd.op  = CELL_ERASE;
                     cell_cmd.pos = CMP_W'(loc_index);
                     count_in     = count_ff - CNT_W'(1);
                     removed_in   = removed_ff + CNT_W'(1);
                     state_in     = ST_DECODE;
                  end else begin
                     res_ok_in = (removed_ff != '0);
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in                          = 1'b1;
               rsp_tdata_in                           = '0;
               rsp_tdata_in[RSP_OK_LSB]               = res_ok_ff;
               rsp_tdata_in[RSP_POS_LSB +: POS_W]     = POS_W'(res_pos_ff);
               rsp_tdata_in[RSP_VAL_LSB +: ITEM_W]    = ITEM_W'(res_val_ff);
               rsp_tdata_in[RSP_REM_LSB +: POS_W]     = POS_W'(removed_ff);
               rsp_tdata_in[RSP_CNT_LSB +: POS_W]     = POS_W'(count_ff);
               state_in                               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cap_ff        <= CAP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      action_ff    <= action_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      removed_ff   <= removed_in;
      res_ok_ff    <= res_ok_in;
      res_pos_ff   <= res_pos_in;
      res_val_ff   <= res_val_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------- checks ----------------
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_IMPLY(a_count_step, clock, reset, !$past(reset),
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff == $past(count_ff) - CNT_W'(1)))
   `ASSERT_NEXT(a_count_quiet, clock, reset,
      (state_ff == ST_IDLE) || (state_ff == ST_LOOK1) || (state_ff == ST_RESP),
      $stable(count_ff))
   `ASSERT_IMPLY(a_rsp_from_resp, clock, reset, !$past(reset) && $rose(rsp_tvalid_ff),
      $past(state_ff) == ST_RESP)

endmodule
